// ===== rtl/sts_pkg.sv =====
package sts_pkg;

    // fixed widths of the result fields
    localparam int FIELD_W = 32;
    localparam int KIND_W  = 4;
    localparam int ERR_W   = 2;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_FN     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LET    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_VOID   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_STRING = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 4'd10;
    localparam logic [KIND_W-1:0] KIND_COLON  = 4'd11;
    localparam logic [KIND_W-1:0] KIND_ARROW  = 4'd12;
    localparam logic [KIND_W-1:0] KIND_EOF    = 4'd13;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd14;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 2'd2;

    // one result word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ERR_W-1:0]   err;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] line;
        logic               last;
    } token_t;

    // results of one accepted item, in order
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

endpackage

// ===== rtl/sts_lexer.sv =====
module sts_lexer #(
    parameter int OFFSET_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    source_byte,
    input  logic          end_of_source,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    output sts_pkg::push_t push
);

    localparam int OW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam logic [OW-1:0] OFF_MAX = '1;
    localparam logic [OW:0]   ONE_W   = 1;

    // characters of interest
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_STRING,
        MODE_SLASH,
        MODE_MINUS,
        MODE_COMMENT
    } mode_t;

    typedef enum logic [3:0] {
        KW_NONE,
        KW_F,
        KW_FN,
        KW_L,
        KW_LE,
        KW_LET,
        KW_V,
        KW_VO,
        KW_VOI,
        KW_VOID
    } kw_t;

    // keyword prefix step
    function automatic kw_t kw_step(input kw_t p, input logic [7:0] c);
        kw_t r;
        r = KW_NONE;
        if (p == KW_F && c == CH_N) r = KW_FN;
        if (p == KW_L && c == CH_E) r = KW_LE;
        if (p == KW_LE && c == CH_T) r = KW_LET;
        if (p == KW_V && c == CH_O) r = KW_VO;
        if (p == KW_VO && c == CH_I) r = KW_VOI;
        if (p == KW_VOI && c == CH_D) r = KW_VOID;
        return r;
    endfunction

    // kind of a finished identifier
    function automatic logic [sts_pkg::KIND_W-1:0] kw_kind(input kw_t p);
        logic [sts_pkg::KIND_W-1:0] k;
        k = sts_pkg::KIND_IDENT;
        if (p == KW_FN) k = sts_pkg::KIND_FN;
        if (p == KW_LET) k = sts_pkg::KIND_LET;
        if (p == KW_VOID) k = sts_pkg::KIND_VOID;
        return k;
    endfunction

    mode_t                 mode_reg, mode_next;
    kw_t                   kw_reg, kw_next;
    logic [OW-1:0]         ts_reg, ts_next;
    logic [OW-1:0]         off_reg, off_next;
    logic [31:0]           line_reg, line_next;
    logic [15:0]           first_line_reg;

    logic                  is_alpha, is_ident;
    logic [OW-1:0]         span_excl, span_incl;
    logic [OW:0]           span_wide;
    logic [31:0]           line_sat;

    logic                  sc_load, sc_emit, sc_nl;
    mode_t                 sc_mode;
    kw_t                   sc_kw;
    sts_pkg::token_t       sc_tok;

    logic                  p_valid, s_valid, use_scan;
    sts_pkg::token_t       p_tok, s_tok;

    // character classes and spans
    assign is_alpha  = (source_byte >= CH_LA && source_byte <= CH_LZ)
                    || (source_byte >= CH_UA && source_byte <= CH_UZ);
    assign is_ident  = is_alpha || source_byte == CH_UNDER
                    || (source_byte >= CH_0 && source_byte <= CH_9);
    assign span_excl = off_reg - ts_reg;
    assign span_wide = {1'b0, off_reg} + ONE_W - {1'b0, ts_reg};
    assign span_incl = span_wide[OW] ? OFF_MAX : span_wide[OW-1:0];
    assign line_sat  = (line_reg == '1) ? line_reg : line_reg + 32'd1;

    // scan of a byte from between tokens
    always_comb
    begin
        sc_mode = MODE_IDLE;
        sc_load = 1'b0;
        sc_emit = 1'b0;
        sc_nl   = 1'b0;
        sc_kw   = KW_NONE;
        sc_tok.kind  = sts_pkg::KIND_ERROR;
        sc_tok.err   = sts_pkg::ERR_NONE;
        sc_tok.start = 32'(off_reg);
        sc_tok.len   = 32'd1;
        sc_tok.line  = line_reg;
        sc_tok.last  = 1'b0;
        unique case (source_byte)
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_LF:     sc_nl = 1'b1;
            CH_SLASH:
            begin
                sc_load = 1'b1;
                sc_mode = MODE_SLASH;
            end
            CH_MINUS:
            begin
                sc_load = 1'b1;
                sc_mode = MODE_MINUS;
            end
            CH_QUOTE:
            begin
                sc_load = 1'b1;
                sc_mode = MODE_STRING;
            end
            CH_LPAREN:
            begin
                sc_emit = 1'b1;
                sc_tok.kind = sts_pkg::KIND_LPAREN;
            end
            CH_RPAREN:
            begin
                sc_emit = 1'b1;
                sc_tok.kind = sts_pkg::KIND_RPAREN;
            end
            CH_LBRACE:
            begin
                sc_emit = 1'b1;
                sc_tok.kind = sts_pkg::KIND_LBRACE;
            end
            CH_RBRACE:
            begin
                sc_emit = 1'b1;
                sc_tok.kind = sts_pkg::KIND_RBRACE;
            end
            CH_SEMI:
            begin
                sc_emit = 1'b1;
                sc_tok.kind = sts_pkg::KIND_SEMI;
            end
            CH_EQUAL:
            begin
                sc_emit = 1'b1;
                sc_tok.kind = sts_pkg::KIND_ASSIGN;
            end
            CH_COLON:
            begin
                sc_emit = 1'b1;
                sc_tok.kind = sts_pkg::KIND_COLON;
            end
            default:
            begin
                if (is_alpha || source_byte == CH_UNDER)
                begin
                    sc_load = 1'b1;
                    sc_mode = MODE_IDENT;
                    if (source_byte == CH_F) sc_kw = KW_F;
                    if (source_byte == CH_L) sc_kw = KW_L;
                    if (source_byte == CH_V) sc_kw = KW_V;
                end
                else
                begin
                    sc_emit = 1'b1;
                    sc_tok.err = sts_pkg::ERR_UNEXPECTED;
                end
            end
        endcase
    end

    // token in progress and next state
    always_comb
    begin
        mode_next = mode_reg;
        kw_next   = kw_reg;
        ts_next   = ts_reg;
        off_next  = (off_reg == OFF_MAX) ? off_reg : off_reg + 1'b1;
        line_next = line_reg;
        use_scan  = 1'b0;
        p_valid   = 1'b0;
        s_valid   = 1'b0;
        p_tok.kind  = sts_pkg::KIND_ERROR;
        p_tok.err   = sts_pkg::ERR_UNEXPECTED;
        p_tok.start = 32'(ts_reg);
        p_tok.len   = 32'd1;
        p_tok.line  = line_reg;
        p_tok.last  = 1'b0;
        s_tok       = sc_tok;
        if (end_of_source)
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    p_valid    = 1'b1;
                    p_tok.kind = kw_kind(kw_reg);
                    p_tok.err  = sts_pkg::ERR_NONE;
                    p_tok.len  = 32'(span_excl);
                end
                MODE_SLASH, MODE_MINUS: p_valid = 1'b1;
                MODE_STRING:
                begin
                    p_valid   = 1'b1;
                    p_tok.err = sts_pkg::ERR_UNTERMINATED;
                    p_tok.len = 32'(span_excl);
                end
                default: ;
            endcase
            s_valid     = 1'b1;
            s_tok.kind  = sts_pkg::KIND_EOF;
            s_tok.err   = sts_pkg::ERR_NONE;
            s_tok.start = 32'(off_reg);
            s_tok.len   = '0;
            mode_next   = MODE_IDLE;
            kw_next     = KW_NONE;
            ts_next     = '0;
            off_next    = '0;
            line_next   = 32'(first_line_reg);
        end
        else
        begin
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    if (source_byte == CH_LF)
                    begin
                        line_next = line_sat;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    if (source_byte == CH_QUOTE)
                    begin
                        p_valid    = 1'b1;
                        p_tok.kind = sts_pkg::KIND_STRING;
                        p_tok.err  = sts_pkg::ERR_NONE;
                        p_tok.len  = 32'(span_incl);
                        mode_next  = MODE_IDLE;
                    end
                    else if (source_byte == CH_LF)
                    begin
                        line_next = line_sat;
                    end
                end
                MODE_SLASH:
                begin
                    if (source_byte == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        p_valid  = 1'b1;
                        use_scan = 1'b1;
                    end
                end
                MODE_MINUS:
                begin
                    if (source_byte == CH_GT)
                    begin
                        p_valid    = 1'b1;
                        p_tok.kind = sts_pkg::KIND_ARROW;
                        p_tok.err  = sts_pkg::ERR_NONE;
                        p_tok.len  = 32'(span_incl);
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        p_valid  = 1'b1;
                        use_scan = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_ident)
                    begin
                        kw_next = kw_step(kw_reg, source_byte);
                    end
                    else
                    begin
                        p_valid    = 1'b1;
                        p_tok.kind = kw_kind(kw_reg);
                        p_tok.err  = sts_pkg::ERR_NONE;
                        p_tok.len  = 32'(span_excl);
                        kw_next    = KW_NONE;
                        use_scan   = 1'b1;
                    end
                end
                default: use_scan = 1'b1;
            endcase
            if (use_scan)
            begin
                mode_next = sc_mode;
                s_valid   = sc_emit;
                if (sc_load)
                begin
                    ts_next = off_reg;
                    kw_next = sc_kw;
                end
                if (sc_nl)
                begin
                    line_next = line_sat;
                end
            end
        end
    end

    // order the results of this word
    always_comb
    begin
        push.second      = s_tok;
        push.second.last = 1'b1;
        if (p_valid)
        begin
            push.first      = p_tok;
            push.first.last = !s_valid;
            push.count      = s_valid ? 2'd2 : 2'd1;
        end
        else
        begin
            push.first      = s_tok;
            push.first.last = 1'b1;
            push.count      = s_valid ? 2'd1 : 2'd0;
        end
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    // scanner state and line register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            kw_reg         <= KW_NONE;
            ts_reg         <= '0;
            off_reg        <= '0;
            line_reg       <= 32'd1;
            first_line_reg <= 16'd1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                first_line_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                mode_reg <= mode_next;
                kw_reg   <= kw_next;
                ts_reg   <= ts_next;
                off_reg  <= off_next;
                line_reg <= line_next;
            end
            else if (cfg_wr_en && off_reg == '0 && mode_reg == MODE_IDLE)
            begin
                line_reg <= 32'(cfg_wr_data);
            end
        end
    end

    // end marker always closes with eof
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_source |->
            (push.count == 2'd1 && push.first.kind == sts_pkg::KIND_EOF)
         || (push.count == 2'd2 && push.second.kind == sts_pkg::KIND_EOF))
        else $error("end marker without eof token");

    // a new source starts from offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_source |=> off_reg == '0 && mode_reg == MODE_IDLE)
        else $error("scanner not restarted after end marker");

    // comment bytes give no tokens
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !end_of_source && mode_reg == MODE_COMMENT |-> push.count == 2'd0)
        else $error("token emitted inside comment");

endmodule

// ===== rtl/sts_result_queue.sv =====
module sts_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  sts_pkg::push_t   push,
    input  logic             out_stall,
    output logic             out_valid,
    output sts_pkg::token_t  head,
    output logic             room
);

    localparam int DEPTH = 3;

    sts_pkg::token_t slot_reg [DEPTH];
    sts_pkg::token_t slot_next [DEPTH];
    logic [1:0]      count_reg, count_next;
    logic [1:0]      base;
    logic            pop;

    assign out_valid = count_reg != 2'd0;
    assign head      = slot_reg[0];
    assign room      = count_reg < 2'd2;
    assign pop       = out_valid && !out_stall;
    assign base      = count_reg - {1'b0, pop};
    assign count_next = base + push.count;

    // shift on pop, then append new words
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            slot_next[j] = slot_reg[j];
            if (pop && j < DEPTH - 1)
            begin
                slot_next[j] = slot_reg[(j < DEPTH - 1) ? j + 1 : j];
            end
            if (push.count != 2'd0 && base == 2'(j))
            begin
                slot_next[j] = push.first;
            end
            if (push.count == 2'd2 && base + 2'd1 == 2'(j))
            begin
                slot_next[j] = push.second;
            end
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            slot_reg[j] <= slot_next[j];
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // words only arrive while two slots are free
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("push into full result queue");

    // a pair carries the last flag on its second word only
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.last && push.second.last)
        else $error("last flag misplaced in pair");

    // draining the only word empties the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 && pop && push.count == 2'd0 |=> !out_valid)
        else $error("queue not empty after final pop");

endmodule

// ===== rtl/source_token_scanner.sv =====
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   source_byte, end_of_source
// output    out        out_valid / out_stall token_kind, error_code, start_offset,
//                                            token_length, line_number, last_of_run
// config    in         cfg_wr_en             cfg_wr_data (first_line)
//
// one input word per cycle while in_stall is low; results are registered in the result queue
// a word with two results can raise in_stall until the queue holds fewer than two (three-slot result queue)
// in_stall depends only on the queue fill, never on out_stall in the same cycle
// rst_n clears scanner state, the queue and sets first_line and the line count to 1
module source_token_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  source_byte,
    input  logic        end_of_source,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [1:0]  error_code,
    output logic [31:0] start_offset,
    output logic [31:0] token_length,
    output logic [31:0] line_number,
    output logic        last_of_run,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    sts_pkg::push_t  push;
    sts_pkg::token_t head;
    logic            room;
    logic            accept;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    // scanner
    sts_lexer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .source_byte  (source_byte),
        .end_of_source(end_of_source),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push)
    );

    // result queue
    sts_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .head     (head),
        .room     (room)
    );

    assign token_kind   = head.kind;
    assign error_code   = head.err;
    assign start_offset = head.start;
    assign token_length = head.len;
    assign line_number  = head.line;
    assign last_of_run  = head.last;

endmodule

// ===== dv/token_checker.sv =====
`timescale 1ns / 100ps

module token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  source_byte,
    input  logic        end_of_source,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  token_kind,
    input  logic [1:0]  error_code,
    input  logic [31:0] start_offset,
    input  logic [31:0] token_length,
    input  logic [31:0] line_number,
    input  logic        last_of_run,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          mismatches,
    output int          pending
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_STRING,
        MODE_SLASH,
        MODE_MINUS,
        MODE_COMMENT
    } lex_mode_t;

    // how much of fn / let / void the current identifier has matched
    typedef enum logic [3:0] {
        KW_NONE,
        KW_F,
        KW_FN,
        KW_L,
        KW_LE,
        KW_LET,
        KW_V,
        KW_VO,
        KW_VOI,
        KW_VOID
    } kw_match_t;

    localparam logic [31:0] OFFSET_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] LINE_MAX     = 32'hFFFF_FFFF;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_NL        = 8'h0A;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_QUOTE     = 8'h22;

    logic [15:0]     first_line;
    lex_mode_t       mode;
    kw_match_t       kw;
    logic [31:0]     tok_start;
    logic [31:0]     offset;
    logic [31:0]     line_cnt;
    sts_pkg::token_t expected_tokens[$];
    int              step_base;
    int              fail_total;

    // length from a start offset to an exclusive end, capped
    function automatic logic [31:0] span_len(logic [31:0] from, logic [32:0] upto);
        logic [32:0] n;
        n = (upto >= {1'b0, from}) ? upto - {1'b0, from} : 33'd0;
        return (n > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : n[31:0];
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic kw_match_t kw_advance(kw_match_t p, logic [7:0] c);
        case (p)
            KW_F:    return (c == "n") ? KW_FN : KW_NONE;
            KW_L:    return (c == "e") ? KW_LE : KW_NONE;
            KW_LE:   return (c == "t") ? KW_LET : KW_NONE;
            KW_V:    return (c == "o") ? KW_VO : KW_NONE;
            KW_VO:   return (c == "i") ? KW_VOI : KW_NONE;
            KW_VOI:  return (c == "d") ? KW_VOID : KW_NONE;
            default: return KW_NONE;
        endcase
    endfunction

    function automatic logic [3:0] word_kind(kw_match_t p);
        case (p)
            KW_FN:   return sts_pkg::KIND_FN;
            KW_LET:  return sts_pkg::KIND_LET;
            KW_VOID: return sts_pkg::KIND_VOID;
            default: return sts_pkg::KIND_IDENT;
        endcase
    endfunction

    // at most two tokens per input word
    task automatic push_token(logic [3:0] k, logic [1:0] e, logic [31:0] s, logic [31:0] n);
        if (expected_tokens.size() - step_base < 2)
            expected_tokens.push_back('{kind: k, err: e, start: s, len: n,
                                        line: line_cnt, last: 1'b0});
    endtask

    task automatic bump_line();
        if (line_cnt != LINE_MAX)
            line_cnt++;
    endtask

    // byte seen between tokens
    task automatic start_fresh(logic [7:0] c, logic [31:0] off);
        mode = MODE_IDLE;
        case (c)
            " ", CH_TAB, CH_CR: ;
            CH_NL:    bump_line();
            "/":
            begin
                tok_start = off;
                mode = MODE_SLASH;
            end
            "-":
            begin
                tok_start = off;
                mode = MODE_MINUS;
            end
            CH_QUOTE:
            begin
                tok_start = off;
                mode = MODE_STRING;
            end
            "(":      push_token(sts_pkg::KIND_LPAREN, sts_pkg::ERR_NONE, off, 32'd1);
            ")":      push_token(sts_pkg::KIND_RPAREN, sts_pkg::ERR_NONE, off, 32'd1);
            "{":      push_token(sts_pkg::KIND_LBRACE, sts_pkg::ERR_NONE, off, 32'd1);
            "}":      push_token(sts_pkg::KIND_RBRACE, sts_pkg::ERR_NONE, off, 32'd1);
            ";":      push_token(sts_pkg::KIND_SEMI, sts_pkg::ERR_NONE, off, 32'd1);
            "=":      push_token(sts_pkg::KIND_ASSIGN, sts_pkg::ERR_NONE, off, 32'd1);
            ":":      push_token(sts_pkg::KIND_COLON, sts_pkg::ERR_NONE, off, 32'd1);
            default:
            begin
                if (is_letter(c) || c == "_")
                begin
                    tok_start = off;
                    mode = MODE_IDENT;
                    kw = (c == "f") ? KW_F : (c == "l") ? KW_L : (c == "v") ? KW_V : KW_NONE;
                end
                else
                begin
                    push_token(sts_pkg::KIND_ERROR, sts_pkg::ERR_UNEXPECTED, off, 32'd1);
                end
            end
        endcase
    endtask

    // predict the tokens caused by one accepted word
    task automatic lex_word(logic [7:0] c, logic eos);
        logic [31:0] off;
        off = offset;
        step_base = expected_tokens.size();
        if (eos)
        begin
            case (mode)
                MODE_IDENT:
                    push_token(word_kind(kw), sts_pkg::ERR_NONE, tok_start,
                               span_len(tok_start, {1'b0, off}));
                MODE_SLASH, MODE_MINUS:
                    push_token(sts_pkg::KIND_ERROR, sts_pkg::ERR_UNEXPECTED, tok_start, 32'd1);
                MODE_STRING:
                    push_token(sts_pkg::KIND_ERROR, sts_pkg::ERR_UNTERMINATED, tok_start,
                               span_len(tok_start, {1'b0, off}));
                default: ;
            endcase
            push_token(sts_pkg::KIND_EOF, sts_pkg::ERR_NONE, off, 32'd0);
            mode = MODE_IDLE;
            kw = KW_NONE;
            tok_start = '0;
            offset = '0;
            line_cnt = {16'd0, first_line};
        end
        else
        begin
            case (mode)
                MODE_COMMENT:
                begin
                    if (c == CH_NL)
                    begin
                        bump_line();
                        mode = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        push_token(sts_pkg::KIND_STRING, sts_pkg::ERR_NONE, tok_start,
                                   span_len(tok_start, {1'b0, off} + 33'd1));
                        mode = MODE_IDLE;
                    end
                    else if (c == CH_NL)
                    begin
                        bump_line();
                    end
                end
                MODE_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode = MODE_COMMENT;
                    end
                    else
                    begin
                        push_token(sts_pkg::KIND_ERROR, sts_pkg::ERR_UNEXPECTED,
                                   tok_start, 32'd1);
                        start_fresh(c, off);
                    end
                end
                MODE_MINUS:
                begin
                    if (c == ">")
                    begin
                        push_token(sts_pkg::KIND_ARROW, sts_pkg::ERR_NONE, tok_start,
                                   span_len(tok_start, {1'b0, off} + 33'd1));
                        mode = MODE_IDLE;
                    end
                    else
                    begin
                        push_token(sts_pkg::KIND_ERROR, sts_pkg::ERR_UNEXPECTED,
                                   tok_start, 32'd1);
                        start_fresh(c, off);
                    end
                end
                MODE_IDENT:
                begin
                    if (is_word_char(c))
                    begin
                        kw = kw_advance(kw, c);
                    end
                    else
                    begin
                        push_token(word_kind(kw), sts_pkg::ERR_NONE, tok_start,
                                   span_len(tok_start, {1'b0, off}));
                        kw = KW_NONE;
                        start_fresh(c, off);
                    end
                end
                default:
                    start_fresh(c, off);
            endcase
            if (offset != OFFSET_MAX)
                offset++;
        end
        if (expected_tokens.size() > step_base)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
        fail_total++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    // watch the channels, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        sts_pkg::token_t want;
        if (!rst_n)
        begin
            first_line = 16'd1;
            mode = MODE_IDLE;
            kw = KW_NONE;
            tok_start = '0;
            offset = '0;
            line_cnt = 32'd1;
            step_base = 0;
            expected_tokens.delete();
            fail_total = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                first_line = cfg_wr_data;
                if (offset == '0 && mode == MODE_IDLE)
                    line_cnt = {16'd0, cfg_wr_data};
            end
            if (in_valid && !in_stall)
                lex_word(source_byte, end_of_source);
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    note_failure("token kind with nothing pending", 32'd0, {28'd0, token_kind});
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                        note_failure("token_kind", {28'd0, want.kind}, {28'd0, token_kind});
                    if (error_code !== want.err)
                        note_failure("error_code", {30'd0, want.err}, {30'd0, error_code});
                    if (start_offset !== want.start)
                        note_failure("start_offset", want.start, start_offset);
                    if (token_length !== want.len)
                        note_failure("token_length", want.len, token_length);
                    if (line_number !== want.line)
                        note_failure("line_number", want.line, line_number);
                    if (last_of_run !== want.last)
                        note_failure("last_of_run", {31'd0, want.last}, {31'd0, last_of_run});
                end
            end
            mismatches <= fail_total;
            pending <= expected_tokens.size();
        end
    end

endmodule

// ===== dv/tb_source_token_scanner.sv =====
`timescale 1ns / 100ps

module tb_source_token_scanner;

    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 240;
    localparam int SETTLE       = 6;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  source_byte;
    logic        end_of_source;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  token_kind;
    logic [1:0]  error_code;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic        last_of_run;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    int          mismatches;
    int          pending;

    bit          in_quiet;
    bit          out_quiet;
    bit          hold_request;
    int          words_sent;
    int          sources_sent;
    int          config_writes;
    int          cycle_count = 0;
    logic [7:0]  src_bytes[$];
    string       word_samples[10] = '{"fn", "let", "void", "fnx", "le", "lets", "vo",
                                      "voidx", "Fn", "_fn"};

    source_token_scanner u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .source_byte(source_byte), .end_of_source(end_of_source),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .error_code(error_code),
        .start_offset(start_offset), .token_length(token_length),
        .line_number(line_number), .last_of_run(last_of_run),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    token_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .source_byte(source_byte), .end_of_source(end_of_source),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .error_code(error_code),
        .start_offset(start_offset), .token_length(token_length),
        .line_number(line_number), .last_of_run(last_of_run),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .mismatches(mismatches), .pending(pending)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens still pending", cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall before each word, one long hold-off on request
    initial
    begin : result_receiver
        int gap;
        bit held;
        held = 1'b0;
        out_stall <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = out_quiet ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // offer one word after a random gap and wait until it is taken
    task automatic send_word(logic [7:0] b, logic eos);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        source_byte <= b;
        end_of_source <= eos;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        sources_sent++;
    endtask

    // wait for every pending token, then let the block settle
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_first_line(logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        config_writes++;
    endtask

    function automatic logic [7:0] pick_word_char(bit lead);
        int unsigned r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            src_bytes.push_back(s[i]);
    endtask

    // one piece of source: mostly well formed, some noise
    task automatic add_fragment();
        int unsigned r;
        int unsigned n;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r < 30 || (r >= 78 && r < 85))
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                push_text(word_samples[$urandom_range(0, 9)]);
            end
            else
            begin
                src_bytes.push_back(pick_word_char(1'b1));
                repeat ($urandom_range(0, 6)) src_bytes.push_back(pick_word_char(1'b0));
            end
            if (r >= 78)
                src_bytes.push_back(8'h0A);
        end
        else if (r < 45)
        begin
            case ($urandom_range(0, 7))
                0: push_text("(");
                1: push_text(")");
                2: push_text("{");
                3: push_text("}");
                4: push_text(";");
                5: push_text("=");
                6: push_text(":");
                default: push_text("->");
            endcase
        end
        else if (r < 60)
        begin
            case ($urandom_range(0, 3))
                0: src_bytes.push_back(" ");
                1: src_bytes.push_back(8'h09);
                2: src_bytes.push_back(8'h0D);
                default: src_bytes.push_back(8'h0A);
            endcase
        end
        else if (r < 70)
        begin
            src_bytes.push_back(8'h22);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0: b = 8'h0A;
                    1: b = 8'($urandom_range(128, 255));
                    default: b = 8'($urandom_range(32, 126));
                endcase
                src_bytes.push_back(b == 8'h22 ? "x" : b);
            end
            src_bytes.push_back(8'h22);
        end
        else if (r < 78)
        begin
            push_text("//");
            repeat ($urandom_range(0, 8))
            begin
                b = 8'($urandom_range(0, 255));
                src_bytes.push_back(b == 8'h0A ? "#" : b);
            end
            src_bytes.push_back(8'h0A);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0, 1: src_bytes.push_back(8'($urandom_range(0, 255)));
                2: src_bytes.push_back("/");
                3: src_bytes.push_back("-");
                default: src_bytes.push_back(8'h22);
            endcase
        end
    endtask

    task automatic send_fragments(int unsigned n);
        src_bytes.delete();
        repeat (n) add_fragment();
        foreach (src_bytes[i])
            send_word(src_bytes[i], 1'b0);
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic [15:0] value;
        int          phase_start;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        source_byte <= 8'd0;
        end_of_source <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 16'd0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        hold_request = 1'b0;
        words_sent = 0;
        sources_sent = 0;
        config_writes = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keywords fn and void, brackets, arrow, identifier at a newline, string over a newline, open comment
        send_text("fn(void)->{x\n\"\n\"}//");
        send_end();
        settle_idle();
        write_first_line(16'hFFFF);
        // lone minus and slash, stray high byte and nul, open string at the end
        send_text("let=:;-/");
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h22, 1'b0);
        send_end();

        for (int p = 0; p < PHASES; p++)
        begin
            settle_idle();
            value = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            write_first_line(value);
            in_quiet = (p == 2) || ($urandom_range(0, 4) == 0);
            out_quiet = (p == 2) || ($urandom_range(0, 4) == 0);
            if (p == 3)
                hold_request = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                send_fragments($urandom_range(0, 10));
                send_end();
            end
            // sometimes leave a source open across the next register write
            if ($urandom_range(0, 1) == 1)
                send_fragments($urandom_range(1, 3));
        end
        send_end();
        settle_idle();

        $display("run covered %0d words in %0d sources with %0d first_line writes",
                 words_sent, sources_sent, config_writes);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
